/* src/rld_pkg.sv */
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, widths and helper functions for the radial lens distortion
// correction pipeline.
// ----------------------------------------------------------------------------
package rld_pkg;

  // Number of Newton iterations and fraction bits of the coordinates.
  localparam int NEWTON_STEPS = 4;
  localparam int FRAC_BITS    = 12;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int COEFF_W = 16;

  // Register indexes of the configuration port.
  localparam logic REG_SUM_MODE = 1'b0;
  localparam logic REG_COEFF    = 1'b1;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd7235;

  // Command codes.
  localparam logic CMD_FORWARD = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  // Squared radius, four times over in summation mode.
  localparam int D_W = 2 * COORD_W + 2;

  // Forward path: coeff * d, scale with 32 fraction bits, scaled coordinate.
  localparam int P_W       = COEFF_W + D_W;
  localparam int FWD_SHIFT = 8 + 2 * FRAC_BITS;
  localparam int TERM_W    = P_W - FWD_SHIFT;
  localparam int SC_W      = ((TERM_W > 32) ? TERM_W : 32) + 1;
  localparam int PZ_W      = COORD_W + SC_W;
  localparam int ENC_W     = PZ_W - 31;

  // Square root: radius with 7 extra fraction bits.
  localparam int V_W        = 64;
  localparam int SQRT_SHIFT = V_W - D_W;
  localparam int R_W        = V_W / 2;
  localparam int RS_W       = R_W + 2;

  // Newton step widths.
  localparam int SQ_W    = 2 * R_W;
  localparam int UP_W    = COEFF_W + SQ_W;
  localparam int U_SHIFT = 22 + 2 * FRAC_BITS;
  localparam int U_W     = UP_W - U_SHIFT;
  localparam int UM_W    = (U_W > 32) ? U_W : 32;
  localparam int DEN_W   = UM_W + 2;
  localparam int NUM_W   = UM_W + 34;

  // Final scaling by s / R.
  localparam int FN_W = COORD_W + R_W + 1;
  localparam int FD_W = R_W + 1;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic               cmd;
    logic               nz;
    logic               nx;
    logic [COORD_W-1:0] rz;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] mz;
    logic [COORD_W-1:0] mx;
    logic [D_W-1:0]     d;
    logic [COORD_W-1:0] fz;
    logic [COORD_W-1:0] fx;
    logic [R_W-1:0]     root;
    logic [R_W-1:0]     s;
  } item_t;

  // Sign and saturate a magnitude back into a two's complement coordinate.
  function automatic logic [COORD_W-1:0] enc(input logic neg,
                                             input logic [ENC_W-1:0] mag);
    logic [ENC_W-1:0] lim;
    logic [ENC_W-1:0] m;
    begin
      lim = ENC_W'(1) << (COORD_W - 1);
      if (neg) begin
        m = (mag > lim) ? lim : mag;
        enc = COORD_W'(0) - m[COORD_W-1:0];
      end else begin
        m = (mag > lim - ENC_W'(1)) ? (lim - ENC_W'(1)) : mag;
        enc = m[COORD_W-1:0];
      end
    end
  endfunction

endpackage

/* src/radial_lens_distortion_correct.sv */
// ----------------------------------------------------------------------------
// radial_lens_distortion_correct
// Applies or removes cubic radial lens distortion on a stream of points.
// ----------------------------------------------------------------------------
// Input beats carry a point (z, x) in signed Q11.12 pixels in in_tdata and
// the command in in_tuser: 0 applies the distortion, 1 removes it. Each input
// beat gives exactly one output beat with the corrected point in out_tdata.
// The configuration port sets summation mode (index 0) and the distortion
// coefficient (index 1); write it only while the pipeline is empty.
// Throughput is one beat per clock while the receiver does not stall. The
// pipeline is made of the front end and forward path, the one-bit-per-stage
// square root, each Newton step's products and 32-stage divider, and the
// final pair of 24-stage dividers.
// Synchronous reset empties the pipeline and restores the register defaults.
// When the receiver stalls, the whole pipeline holds; in_tready follows
// out_tready whenever a result is waiting, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module radial_lens_distortion_correct (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coord_z [23:0], coord_x [47:24]
  input  logic [0:0]  in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_z [23:0], out_x [47:24]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rld_pkg::*;

  logic               sum_mode_r;
  logic [COEFF_W-1:0] coeff_r;
  logic               en;
  logic               f_vld, q_vld;
  item_t              f_item, q_item;
  logic               n_vld  [NEWTON_STEPS+1];
  item_t              n_item [NEWTON_STEPS+1];
  logic [COORD_W-1:0] oz, ox;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_mode_r <= 1'b0;
      coeff_r    <= COEFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        REG_SUM_MODE: sum_mode_r <= cfg_data[0];
        REG_COEFF:    coeff_r    <= cfg_data[COEFF_W-1:0];
        default:      ;
      endcase
    end
  end

  // The pipeline moves whenever the output stage is empty or being taken.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  rld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .sum_mode (sum_mode_r),
    .coeff    (coeff_r),
    .in_vld   (in_tvalid),
    .in_cmd   (in_tuser[0]),
    .in_z     (in_tdata[COORD_W-1:0]),
    .in_x     (in_tdata[2*COORD_W-1:COORD_W]),
    .out_vld  (f_vld),
    .out_item (f_item)
  );

  rld_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_item  (f_item),
    .out_vld  (q_vld),
    .out_item (q_item)
  );

  assign n_vld[0]  = q_vld;
  assign n_item[0] = q_item;

  // Chain of Newton steps.
  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
    rld_newton u_newton (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .coeff    (coeff_r),
      .in_vld   (n_vld[i]),
      .in_item  (n_item[i]),
      .out_vld  (n_vld[i+1]),
      .out_item (n_item[i+1])
    );
  end

  rld_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (n_vld[NEWTON_STEPS]),
    .in_item (n_item[NEWTON_STEPS]),
    .out_vld (out_tvalid),
    .out_z   (oz),
    .out_x   (ox)
  );

  assign out_tdata = {ox, oz};

endmodule

/* src/rld_front.sv */
// ----------------------------------------------------------------------------
// rld_front
// Magnitudes, squared radius and the complete forward distortion path.
// ----------------------------------------------------------------------------
module rld_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   sum_mode,
  input  logic [rld_pkg::COEFF_W-1:0] coeff,
  input  logic                   in_vld,
  input  logic                   in_cmd,
  input  logic [rld_pkg::COORD_W-1:0] in_z,
  input  logic [rld_pkg::COORD_W-1:0] in_x,
  output logic                   out_vld,
  output rld_pkg::item_t         out_item
);
  import rld_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0]        vld_r;
  item_t                 it1_r, it2_r, it3_r, it4_r, it5_r, it6_r, it7_r;
  item_t                 it1_nxt, it3_nxt, it7_nxt;
  logic [2*COORD_W-1:0]  sqz_r, sqx_r;
  logic [P_W-1:0]        p_r;
  logic [SC_W-1:0]       scale_r;
  logic [PZ_W-1:0]       pz_r, px_r;
  logic [D_W-1:0]        d_nxt;
  logic [P_W:0]          p_rnd;
  logic [PZ_W:0]         pz_rnd, px_rnd;

  // First stage: signs and magnitudes.
  always_comb begin
    it1_nxt     = '0;
    it1_nxt.cmd = in_cmd;
    it1_nxt.rz  = in_z;
    it1_nxt.rx  = in_x;
    it1_nxt.nz  = in_z[COORD_W-1];
    it1_nxt.nx  = in_x[COORD_W-1];
    it1_nxt.mz  = in_z[COORD_W-1] ? (~in_z + COORD_W'(1)) : in_z;
    it1_nxt.mx  = in_x[COORD_W-1] ? (~in_x + COORD_W'(1)) : in_x;
  end

  // Squared radius, doubled radius in summation mode.
  always_comb begin
    d_nxt = D_W'(sqz_r) + D_W'(sqx_r);
    if (sum_mode) begin
      d_nxt = d_nxt << 2;
    end
  end

  // Item of the third stage carries the squared radius.
  always_comb begin
    it3_nxt   = it2_r;
    it3_nxt.d = d_nxt;
  end

  // Rounded products of the forward path.
  assign p_rnd  = (P_W + 1)'(p_r) + ((P_W + 1)'(1) << (FWD_SHIFT - 1));
  assign pz_rnd = (PZ_W + 1)'(pz_r) + ((PZ_W + 1)'(1) << 31);
  assign px_rnd = (PZ_W + 1)'(px_r) + ((PZ_W + 1)'(1) << 31);

  // Item of the last stage carries the forward result.
  always_comb begin
    it7_nxt    = it6_r;
    it7_nxt.fz = enc(it6_r.nz, ENC_W'(pz_rnd >> 32));
    it7_nxt.fx = enc(it6_r.nx, ENC_W'(px_rnd >> 32));
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= it1_nxt;
      it2_r   <= it1_r;
      sqz_r   <= (2*COORD_W)'(it1_r.mz) * (2*COORD_W)'(it1_r.mz);
      sqx_r   <= (2*COORD_W)'(it1_r.mx) * (2*COORD_W)'(it1_r.mx);
      it3_r   <= it3_nxt;
      it4_r   <= it3_r;
      p_r     <= P_W'(coeff) * P_W'(it3_r.d);
      it5_r   <= it4_r;
      scale_r <= (SC_W'(1) << 32) + SC_W'(p_rnd >> FWD_SHIFT);
      it6_r   <= it5_r;
      pz_r    <= PZ_W'(it5_r.mz) * PZ_W'(scale_r);
      px_r    <= PZ_W'(it5_r.mx) * PZ_W'(scale_r);
      it7_r   <= it7_nxt;
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_item = it7_r;

endmodule

/* src/rld_sqrt.sv */
// ----------------------------------------------------------------------------
// rld_sqrt
// Pipelined square root of d * 2^14, one result bit per stage.
// ----------------------------------------------------------------------------
module rld_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  rld_pkg::item_t in_item,
  output logic           out_vld,
  output rld_pkg::item_t out_item
);
  import rld_pkg::*;

  logic [R_W-1:0]  vld_r;
  item_t           it_r   [R_W];
  logic [RS_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]  root_r [R_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[R_W-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    item_t           src_it;
    logic [RS_W-1:0] src_rem;
    logic [R_W-1:0]  src_root;
    logic [V_W-1:0]  v;
    logic [RS_W+1:0] t;
    logic [RS_W+1:0] trial;

    if (k == 0) begin : g_first
      assign src_it   = in_item;
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_it   = it_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    assign v     = V_W'(src_it.d) << SQRT_SHIFT;
    assign t     = {src_rem, v[2*(R_W-1-k)+1 -: 2]};
    assign trial = (RS_W + 2)'({src_root, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[k] <= src_it;
        if (t >= trial) begin
          rem_r[k]  <= RS_W'(t - trial);
          root_r[k] <= {src_root[R_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= RS_W'(t);
          root_r[k] <= {src_root[R_W-2:0], 1'b0};
        end
      end
    end
  end

  // The root is also the starting guess of the Newton iteration.
  always_comb begin
    out_item      = it_r[R_W-1];
    out_item.root = root_r[R_W-1];
    out_item.s    = root_r[R_W-1];
  end
  assign out_vld = vld_r[R_W-1];

endmodule

/* src/rld_newton.sv */
// ----------------------------------------------------------------------------
// rld_newton
// One pipelined Newton step for k*s^3 + s = R: products, then a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module rld_newton (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [rld_pkg::COEFF_W-1:0] coeff,
  input  logic                   in_vld,
  input  rld_pkg::item_t         in_item,
  output logic                   out_vld,
  output rld_pkg::item_t         out_item
);
  import rld_pkg::*;

  localparam int PRE = 4;
  localparam int NST = PRE + R_W;

  logic [NST-1:0]   vld_r;
  item_t            it1_r, it2_r, it3_r, it4_r;
  logic [SQ_W-1:0]  sq_r;
  logic [UP_W-1:0]  p_r;
  logic [UM_W-1:0]  u_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [UP_W:0]    p_rnd;

  item_t            dit_r  [R_W];
  logic [NUM_W-1:0] dnum_r [R_W];
  logic [DEN_W-1:0] dden_r [R_W];
  logic [DEN_W-1:0] drem_r [R_W];
  logic [R_W-1:0]   dq_r   [R_W];

  assign p_rnd = (UP_W + 1)'(p_r) + ((UP_W + 1)'(1) << (U_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // u = k*s^2 with 32 fraction bits, then numerator and divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      sq_r  <= SQ_W'(in_item.s) * SQ_W'(in_item.s);
      it2_r <= it1_r;
      p_r   <= UP_W'(coeff) * UP_W'(sq_r);
      it3_r <= it2_r;
      u_r   <= UM_W'(p_rnd >> U_SHIFT);
      it4_r <= it3_r;
      num_r <= ((NUM_W'(u_r) * NUM_W'(it3_r.s)) << 1) + (NUM_W'(it3_r.root) << 32);
      den_r <= DEN_W'(u_r) + (DEN_W'(u_r) << 1) + (DEN_W'(1) << 32);
    end
  end

  for (genvar k = 0; k < R_W; k++) begin : g_div
    item_t            src_it;
    logic [NUM_W-1:0] src_num;
    logic [DEN_W-1:0] src_den;
    logic [DEN_W-1:0] src_rem;
    logic [R_W-1:0]   src_q;
    logic [DEN_W:0]   t;

    if (k == 0) begin : g_first
      assign src_it  = it4_r;
      assign src_num = num_r;
      assign src_den = den_r;
      assign src_rem = num_r[NUM_W-1:32];
      assign src_q   = '0;
    end else begin : g_next
      assign src_it  = dit_r[k-1];
      assign src_num = dnum_r[k-1];
      assign src_den = dden_r[k-1];
      assign src_rem = drem_r[k-1];
      assign src_q   = dq_r[k-1];
    end

    // Shift in the next numerator bit and subtract where the divisor fits.
    assign t = {src_rem, src_num[R_W-1-k]};

    always_ff @(posedge clk) begin
      if (en) begin
        dit_r[k]  <= src_it;
        dnum_r[k] <= src_num;
        dden_r[k] <= src_den;
        if (t >= {1'b0, src_den}) begin
          drem_r[k] <= DEN_W'(t - {1'b0, src_den});
          dq_r[k]   <= {src_q[R_W-2:0], 1'b1};
        end else begin
          drem_r[k] <= DEN_W'(t);
          dq_r[k]   <= {src_q[R_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    out_item   = dit_r[R_W-1];
    out_item.s = dq_r[R_W-1];
  end
  assign out_vld = vld_r[NST-1];

endmodule

/* src/rld_scale.sv */
// ----------------------------------------------------------------------------
// rld_scale
// Inverse scaling of both coordinates by s / R with a pair of pipelined
// dividers, and selection of the result for the command.
// ----------------------------------------------------------------------------
module rld_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  rld_pkg::item_t         in_item,
  output logic                   out_vld,
  output logic [rld_pkg::COORD_W-1:0] out_z,
  output logic [rld_pkg::COORD_W-1:0] out_x
);
  import rld_pkg::*;

  localparam int NST = 2 + COORD_W + 1;
  localparam int PR_W = COORD_W + R_W;

  logic [NST-1:0]    vld_r;
  item_t             it1_r, it2_r;
  logic [PR_W-1:0]   pz_r, px_r;
  logic [FN_W-1:0]   nz_r, nx_r;
  logic [FD_W-1:0]   den_r;
  logic [COORD_W-1:0] oz_r, ox_r;

  item_t              dit_r [COORD_W];
  logic [FN_W-1:0]    dnz_r [COORD_W];
  logic [FN_W-1:0]    dnx_r [COORD_W];
  logic [FD_W-1:0]    dden_r [COORD_W];
  logic [FD_W-1:0]    rz_r [COORD_W];
  logic [FD_W-1:0]    rx_r [COORD_W];
  logic [COORD_W-1:0] qz_r [COORD_W];
  logic [COORD_W-1:0] qx_r [COORD_W];
  item_t              lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  // Products |c|*s, then the rounded numerators and the divisor 2R.
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r <= in_item;
      pz_r  <= PR_W'(in_item.mz) * PR_W'(in_item.s);
      px_r  <= PR_W'(in_item.mx) * PR_W'(in_item.s);
      it2_r <= it1_r;
      nz_r  <= (FN_W'(pz_r) << 1) + FN_W'(it1_r.root);
      nx_r  <= (FN_W'(px_r) << 1) + FN_W'(it1_r.root);
      den_r <= FD_W'(it1_r.root) << 1;
    end
  end

  for (genvar k = 0; k < COORD_W; k++) begin : g_div
    item_t              src_it;
    logic [FN_W-1:0]    src_nz, src_nx;
    logic [FD_W-1:0]    src_den, src_rz, src_rx;
    logic [COORD_W-1:0] src_qz, src_qx;
    logic [FD_W:0]      tz, tx;

    if (k == 0) begin : g_first
      assign src_it  = it2_r;
      assign src_nz  = nz_r;
      assign src_nx  = nx_r;
      assign src_den = den_r;
      assign src_rz  = nz_r[FN_W-1:COORD_W];
      assign src_rx  = nx_r[FN_W-1:COORD_W];
      assign src_qz  = '0;
      assign src_qx  = '0;
    end else begin : g_next
      assign src_it  = dit_r[k-1];
      assign src_nz  = dnz_r[k-1];
      assign src_nx  = dnx_r[k-1];
      assign src_den = dden_r[k-1];
      assign src_rz  = rz_r[k-1];
      assign src_rx  = rx_r[k-1];
      assign src_qz  = qz_r[k-1];
      assign src_qx  = qx_r[k-1];
    end

    // One quotient bit of each coordinate per stage.
    assign tz = {src_rz, src_nz[COORD_W-1-k]};
    assign tx = {src_rx, src_nx[COORD_W-1-k]};

    always_ff @(posedge clk) begin
      if (en) begin
        dit_r[k]  <= src_it;
        dnz_r[k]  <= src_nz;
        dnx_r[k]  <= src_nx;
        dden_r[k] <= src_den;
        if (tz >= {1'b0, src_den}) begin
          rz_r[k] <= FD_W'(tz - {1'b0, src_den});
          qz_r[k] <= {src_qz[COORD_W-2:0], 1'b1};
        end else begin
          rz_r[k] <= FD_W'(tz);
          qz_r[k] <= {src_qz[COORD_W-2:0], 1'b0};
        end
        if (tx >= {1'b0, src_den}) begin
          rx_r[k] <= FD_W'(tx - {1'b0, src_den});
          qx_r[k] <= {src_qx[COORD_W-2:0], 1'b1};
        end else begin
          rx_r[k] <= FD_W'(tx);
          qx_r[k] <= {src_qx[COORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign lit = dit_r[COORD_W-1];

  // Output register: forward result, pass-through at zero radius, or the
  // signed and saturated inverse result.
  always_ff @(posedge clk) begin
    if (en) begin
      if (lit.cmd == CMD_FORWARD) begin
        oz_r <= lit.fz;
        ox_r <= lit.fx;
      end else if (lit.root == '0) begin
        oz_r <= lit.rz;
        ox_r <= lit.rx;
      end else begin
        oz_r <= enc(lit.nz, ENC_W'(qz_r[COORD_W-1]));
        ox_r <= enc(lit.nx, ENC_W'(qx_r[COORD_W-1]));
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_z   = oz_r;
  assign out_x   = ox_r;

endmodule

/* tb/radial_lens_distortion_correct_tb.sv */
// ----------------------------------------------------------------------------
// radial_lens_distortion_correct_tb
// Self-checking bench for the radial lens distortion pipeline. A bit-exact
// model of the forward scaling and the Newton-based inverse predicts each
// output beat. Output beats are compared in order against the predictions.
// The run covers directed corner points, random phases under several
// register settings, random gaps on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module radial_lens_distortion_correct_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rld_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 260;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // coord_z [23:0], coord_x [47:24]
  logic [0:0]  in_tuser = '0;   // command [0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // out_z [23:0], out_x [47:24]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the registers, used by the predictor.
  logic               sum_mode_q;
  logic [COEFF_W-1:0] coeff_q;

  logic [47:0] point_queue[$];
  int          mismatches;
  int          beats_in;
  int          beats_out;
  int          fwd_count;
  int          inv_count;
  int          rx_stall_len;
  int          rx_mode;
  int          idle_cycles;

  radial_lens_distortion_correct u_top (.*);

  always #10 clk = ~clk;

  // Round half up and shift right, saturating to 64 bits.
  function automatic logic [63:0] shift_round(input logic [127:0] a, input int n);
    logic [127:0] t;
    t = (a + (128'd1 << (n - 1))) >> n;
    if (t[127:64] != 0) return '1;
    return t[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] sign_saturate(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h800000) mag = 64'h800000;
      return 24'(25'h1000000 - mag[24:0]);
    end
    if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
    return mag[23:0];
  endfunction

  // Predicts the corrected point for one input beat: out_x in the top half.
  function automatic logic [47:0] correct_point(input logic cmd, input logic [23:0] z,
                                                input logic [23:0] x);
    logic        nz, nx;
    logic [63:0] mz, mx, d, term, scale, r, s, u, qz, qx;
    logic [127:0] num;
    nz = z[23];
    nx = x[23];
    mz = nz ? 64'h1000000 - z : 64'(z);
    mx = nx ? 64'h1000000 - x : 64'(x);
    d = mz * mz + mx * mx;
    if (sum_mode_q) d = d << 2;
    if (cmd == CMD_FORWARD) begin
      term = shift_round(128'(coeff_q) * 128'(d), FWD_SHIFT);
      scale = (64'd1 << 32) + term;
      qz = shift_round(128'(mz) * 128'(scale), 32);
      qx = shift_round(128'(mx) * 128'(scale), 32);
    end else begin
      r = int_sqrt(d << 14);
      if (r == 0) return {x, z};
      s = r;
      for (int i = 0; i < NEWTON_STEPS; i++) begin
        u = shift_round(128'(coeff_q) * 128'(64'(s * s)), U_SHIFT);
        num = 128'(64'(2 * u)) * 128'(s) + 128'(64'(r << 32));
        s = 64'(num / 128'(64'(3 * u + (64'd1 << 32))));
      end
      qz = 64'(mz * s * 2 + r) / (2 * r);
      qx = 64'(mx * s * 2 + r) / (2 * r);
    end
    return {sign_saturate(nx, qx), sign_saturate(nz, qz)};
  endfunction

  // Compare every output beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_out <= beats_out + 1;
      if (point_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Unexpected output beat %h", out_tdata);
      end else begin
        logic [47:0] want;
        want = point_queue.pop_front();
        if (want[23:0] !== out_tdata[23:0] || want[47:24] !== out_tdata[47:24]) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("Mismatch: out_z exp %h got %h, out_x exp %h got %h",
                     want[23:0], out_tdata[23:0], want[47:24], out_tdata[47:24]);
        end
      end
    end
  end

  // Receiver: random ready with stretches of full rate, plus requested stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (rx_stall_len) @(posedge clk);
        rx_stall_len = 0;
      end
      if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 39) != 0) || ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d beats outstanding", point_queue.size());
      $display("radial_lens_distortion_correct_tb NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Offer one point and wait until it is accepted.
  task automatic send_point(input logic cmd, input logic [23:0] z, input logic [23:0] x,
                            input int gap);
    in_tvalid <= 1'b1;
    in_tdata <= {x, z};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    point_queue.push_back(correct_point(cmd, z, x));
    beats_in = beats_in + 1;
    if (cmd == CMD_FORWARD) fwd_count = fwd_count + 1;
    else inv_count = inv_count + 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (point_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_SUM_MODE) sum_mode_q = value[0];
    else coeff_q = value;
  endtask

  task automatic set_config(input logic mode, input logic [15:0] coeff);
    drain();
    write_reg(REG_SUM_MODE, {15'd0, mode});
    write_reg(REG_COEFF, coeff);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] random_coord();
    case ($urandom_range(0, 4))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8191)) - 4096);
      2: return 24'($signed($urandom_range(0, 2097151)) - 1048576);
      3: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      default: return 24'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  // Corner points under the current register settings.
  task automatic test_directed();
    logic [23:0] pts[8];
    pts = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF,
            24'h800000, 24'h001000, 24'hFFF000, 24'h3A5C0F};
    for (int i = 0; i < 8; i++) begin
      send_point(CMD_FORWARD, pts[i], pts[7 - i], 0);
      send_point(CMD_INVERSE, pts[i], pts[(i + 3) % 8], 1);
    end
    // Zero radius on both commands, then a point on each axis.
    send_point(CMD_INVERSE, 24'h0, 24'h0, 0);
    send_point(CMD_FORWARD, 24'h0, 24'h0, 0);
    send_point(CMD_INVERSE, 24'h0, 24'h7FFFFF, 0);
    send_point(CMD_FORWARD, 24'h800000, 24'h0, 0);
  endtask

  task automatic test_random_phase(input int count);
    for (int i = 0; i < count; i++)
      send_point(logic'($urandom_range(0, 1)), random_coord(), random_coord(), pick_gap());
  endtask

  // Receiver holds off for a long stretch while points keep coming.
  task automatic test_backpressure();
    rx_stall_len = 600;
    for (int i = 0; i < 300; i++)
      send_point(logic'($urandom_range(0, 1)), random_coord(), random_coord(), 0);
  endtask

  initial begin
    sum_mode_q = 1'b0;
    coeff_q = COEFF_RESET;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    fwd_count = 0;
    inv_count = 0;
    rx_stall_len = 0;
    rx_mode = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(250);
    set_config(1'b1, 16'hFFFF);
    test_directed();
    test_random_phase(250);
    set_config(1'b0, 16'd1);
    test_random_phase(200);
    set_config(1'b1, 16'd1);
    test_random_phase(200);
    set_config(1'b0, 16'hFFFF);
    test_random_phase(250);
    test_backpressure();
    set_config(logic'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)));
    test_random_phase(360);
    drain();

    $display("Sent %0d points (%0d forward, %0d inverse), received %0d results,",
             beats_in, fwd_count, inv_count, beats_out);
    $display("over six register settings with random gaps and one long stall.");
    if (mismatches == 0 && point_queue.size() == 0) begin
      $display("radial_lens_distortion_correct_tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, point_queue.size());
      $display("radial_lens_distortion_correct_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rld_pkg.sv
src/rld_front.sv
src/rld_sqrt.sv
src/rld_newton.sv
src/rld_scale.sv
src/radial_lens_distortion_correct.sv
tb/radial_lens_distortion_correct_tb.sv
